@@ hdl/utf8sd_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int LEN_W  = 3;
    localparam int CNT_W  = 3;

    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

    localparam logic [CP_W-1:0] CP_MIN_TWO   = 21'h00080;
    localparam logic [CP_W-1:0] CP_MIN_THREE = 21'h00800;
    localparam logic [CP_W-1:0] CP_MIN_FOUR  = 21'h10000;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h0D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h0DFFF;

    // one group of results caused by a single input word: cnt results, all
    // errors except the last, which carries cp and len (an error if len is 0)
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
        logic             eot;
    } t_group;

    // range checks made when the final byte of a sequence arrives
    function automatic logic seq_valid(input logic [CP_W-1:0] cp,
                                       input logic [LEN_W-1:0] len);
        logic ok;
        ok = 1'b0;
        case (len)
            LEN_TWO:   ok = (cp >= CP_MIN_TWO);
            LEN_THREE: ok = (cp >= CP_MIN_THREE) &&
                            !((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI));
            LEN_FOUR:  ok = (cp >= CP_MIN_FOUR) && (cp <= CP_MAX);
            default:   ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

@@ hdl/utf8sd_decode.sv @@
// ----------------------------------------------------------------------------
// utf8sd_decode
// Sequence state registers and the per-word decode into a result group.
// ----------------------------------------------------------------------------
module utf8sd_decode import utf8sd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_end_of_text,
    output t_group            o_group
);

    logic [CP_W-1:0]  r_pv, n_pv;
    logic [LEN_W-1:0] r_exp, n_exp;
    logic [LEN_W-1:0] r_bt, n_bt;

    logic [CP_W-1:0]  pv_shift;
    logic [LEN_W-1:0] bt_inc;
    logic             is_cont;
    logic [CNT_W-1:0] err_cnt;
    logic             lead_res;
    logic [CP_W-1:0]  lead_cp;
    logic [LEN_W-1:0] lead_len;
    logic [LEN_W-1:0] lead_seq_len;
    logic [CP_W-1:0]  lead_bits;

    assign is_cont  = (i_data_byte[7:6] == 2'b10);
    assign pv_shift = {r_pv[CP_W-7:0], i_data_byte[5:0]};
    assign bt_inc   = r_bt + LEN_ONE;

    // lead byte classification
    always_comb begin
        lead_seq_len = LEN_NONE;
        lead_bits    = '0;
        if (i_data_byte[7] == 1'b0) begin
            lead_seq_len = LEN_ONE;
        end else if (i_data_byte[7:5] == 3'b110) begin
            lead_seq_len = LEN_TWO;
            lead_bits    = {16'd0, i_data_byte[4:0]};
        end else if (i_data_byte[7:4] == 4'b1110) begin
            lead_seq_len = LEN_THREE;
            lead_bits    = {17'd0, i_data_byte[3:0]};
        end else if (i_data_byte[7:3] == 5'b11110) begin
            lead_seq_len = LEN_FOUR;
            lead_bits    = {18'd0, i_data_byte[2:0]};
        end
    end

    always_comb begin
        n_pv     = r_pv;
        n_exp    = r_exp;
        n_bt     = r_bt;
        err_cnt  = '0;
        lead_res = 1'b0;
        lead_cp  = '0;
        lead_len = LEN_NONE;
        o_group  = '0;
        o_group.eot = i_end_of_text;

        if (r_exp != LEN_NONE && is_cont) begin
            n_pv = pv_shift;
            n_bt = bt_inc;
            if (bt_inc >= r_exp) begin
                if (seq_valid(pv_shift, r_exp)) begin
                    o_group.cnt = 3'd1;
                    o_group.cp  = pv_shift;
                    o_group.len = r_exp;
                end else begin
                    o_group.cnt = r_exp;
                end
                n_pv  = '0;
                n_exp = LEN_NONE;
                n_bt  = LEN_NONE;
            end else if (i_end_of_text) begin
                o_group.cnt = bt_inc;
                n_pv  = '0;
                n_exp = LEN_NONE;
                n_bt  = LEN_NONE;
            end
        end else begin
            // a broken sequence flushes what it took, then this word is a lead
            if (r_exp != LEN_NONE) begin
                err_cnt = r_bt;
            end
            n_pv  = '0;
            n_exp = LEN_NONE;
            n_bt  = LEN_NONE;
            if (lead_seq_len == LEN_ONE) begin
                lead_res = 1'b1;
                lead_cp  = {13'd0, i_data_byte};
                lead_len = LEN_ONE;
            end else if (lead_seq_len == LEN_NONE || i_end_of_text) begin
                lead_res = 1'b1;
            end else begin
                n_pv  = lead_bits;
                n_exp = lead_seq_len;
                n_bt  = LEN_ONE;
            end
            o_group.cnt = err_cnt + {2'd0, lead_res};
            o_group.cp  = lead_cp;
            o_group.len = lead_len;
        end

        if (i_end_of_text) begin
            n_pv  = '0;
            n_exp = LEN_NONE;
            n_bt  = LEN_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= '0;
            r_exp <= LEN_NONE;
            r_bt  <= LEN_NONE;
        end else if (i_accept) begin
            r_pv  <= n_pv;
            r_exp <= n_exp;
            r_bt  <= n_bt;
        end
    end

endmodule

@@ hdl/utf8sd_emit.sv @@
// ----------------------------------------------------------------------------
// utf8sd_emit
// Result register: holds one group and hands it out one result per word.
// ----------------------------------------------------------------------------
module utf8sd_emit import utf8sd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_group           i_group,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [CP_W-1:0]  o_code_point,
    output logic [LEN_W-1:0] o_seq_length,
    output logic             o_run_last,
    output logic             o_text_done
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CP_W-1:0]  r_cp;
    logic [LEN_W-1:0] r_len;
    logic             r_eot;
    logic             last;

    assign last    = (r_cnt == 3'd1);
    assign o_valid = (r_cnt != '0);
    // free when empty, or when the last result of the group leaves now
    assign o_free  = (r_cnt == '0) || (last && i_ready);

    assign o_code_point = last ? r_cp  : '0;
    assign o_seq_length = last ? r_len : LEN_NONE;
    assign o_run_last   = last;
    assign o_text_done  = last && r_eot;

    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_group.cnt;
        end else if (o_valid && i_ready) begin
            n_cnt = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cp  <= i_group.cp;
            r_len <= i_group.len;
            r_eot <= i_group.eot;
        end
    end

endmodule

@@ hdl/utf8_stream_decoder_core.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// UTF-8 byte stream to Unicode scalar values, with error results.
// ----------------------------------------------------------------------------
// One byte is taken per cycle unless stalled. A byte is decoded in the cycle
// it is accepted; its results go to a result register that hands them out one
// per cycle while the output is ready. While a group of several results
// drains, the input stalls, so a byte that causes n results (n up to 4) holds
// the output until all are taken; the next byte is accepted in the cycle the
// last is taken. Bytes with zero or one result stream at one per cycle.
module utf8_stream_decoder_core import utf8sd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_end_of_text,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CP_W-1:0]   o_code_point,
    output logic [LEN_W-1:0]  o_seq_length,
    output logic              o_run_last,
    output logic              o_text_done
);

    logic   accept;
    logic   free;
    t_group group;

    assign o_in_ready = free;
    assign accept     = i_in_valid && free;

    utf8sd_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_group       (group)
    );

    utf8sd_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_group      (group),
        .o_free       (free),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_code_point (o_code_point),
        .o_seq_length (o_seq_length),
        .o_run_last   (o_run_last),
        .o_text_done  (o_text_done)
    );

endmodule
